>>> sv/sorted_descending_unique_insert_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sorted insert core checkers.
// ---------------------------------------------------------------------------
`ifndef SORTED_DESCENDING_UNIQUE_INSERT_CORE_DEFINES_SVH
`define SORTED_DESCENDING_UNIQUE_INSERT_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SDUI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SDUI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/sdui_pkg.sv
// ---------------------------------------------------------------------------
// sdui_pkg
// Widths, codes and cell interface types for the sorted insert core.
// ---------------------------------------------------------------------------
package sdui_pkg;

  localparam int DATA_W       = 32;
  localparam int INDEX_W      = 4;
  localparam int COUNT_W      = 5;
  localparam int STATUS_W     = 3;
  localparam int CAPACITY_DEF = 16;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_READ_OK   = 3'd3,
    ST_BEYOND    = 3'd4
  } status_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic                     load;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

  // Compare result of one cell against the broadcast value.
  typedef struct packed {
    logic gt;
    logic eq;
  } cell_flag_t;

endpackage

>>> sv/sdui_req_if.sv
// ---------------------------------------------------------------------------
// sdui_req_if
// Request channel: insert or read item with valid/ready handshake.
// ---------------------------------------------------------------------------
interface sdui_req_if import sdui_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [DATA_W-1:0]  new_value;
  logic        [INDEX_W-1:0] read_index;

  modport source (output valid, output kind, output new_value, output read_index,
                  input ready);
  modport sink   (input valid, input kind, input new_value, input read_index,
                  output ready);
endinterface

>>> sv/sdui_rsp_if.sv
// ---------------------------------------------------------------------------
// sdui_rsp_if
// Response channel: status, position, data and count with valid/ready.
// ---------------------------------------------------------------------------
interface sdui_rsp_if import sdui_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic        [STATUS_W-1:0] status;
  logic        [INDEX_W-1:0]  position;
  logic signed [DATA_W-1:0]   entry_data;
  logic        [COUNT_W-1:0]  entry_count;

  modport source (output valid, output status, output position, output entry_data,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input position, input entry_data,
                  input entry_count, output ready);
endinterface

>>> sv/sdui_cell.sv
// ---------------------------------------------------------------------------
// sdui_cell
// One table slot: compares against the broadcast value and shifts on insert.
// ---------------------------------------------------------------------------
module sdui_cell import sdui_pkg::*; (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic                     occupied,
  input  logic signed [DATA_W-1:0] left_entry,
  input  logic                     left_gt,
  output logic signed [DATA_W-1:0] entry,
  output cell_flag_t               flag
);

  assign flag.gt = occupied && (entry > ctl.value);
  assign flag.eq = occupied && (entry == ctl.value);

  // Keep greater entries; the first slot past them takes the new value,
  // every later slot takes its left neighbor.
  always_ff @(posedge clk) begin
    if (ctl.load && !flag.gt) begin
      entry <= left_gt ? ctl.value : left_entry;
    end
  end

endmodule

>>> sv/sorted_descending_unique_insert_core.sv
// ---------------------------------------------------------------------------
// sorted_descending_unique_insert_core
// Strictly descending table of signed values kept in a row of shift cells.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    kind, new_value, read_index
//   rsp      out  valid/ready    status, position, entry_data, entry_count
//
// An accepted beat is held in the item register until the step fires; then all
// cells compare and shift and the response register loads at the same edge.
// Sustained rate is one item per cycle while rsp is not stalled; a beat passes
// through the item register and then the response register, which sets rsp.valid.
// A stalled rsp holds the item register, which then holds req.ready low.
// Reset clears the count and handshake state; the table needs no clearing.
// ---------------------------------------------------------------------------
module sorted_descending_unique_insert_core import sdui_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic      clk,
  input logic      rst,
  sdui_req_if.sink   req,
  sdui_rsp_if.source rsp
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int READ_N = (CAPACITY < (1 << INDEX_W)) ? CAPACITY : (1 << INDEX_W);
  localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  logic                      busy;
  logic                      item_kind;
  logic signed [DATA_W-1:0]  item_value;
  logic        [INDEX_W-1:0] item_index;
  logic        [CNT_W-1:0]   count;
  logic        [CNT_W-1:0]   count_next;

  logic                      step;
  logic                      full;
  logic                      any_eq;
  logic                      ins_go;
  logic                      read_ok;
  logic        [IDX_W-1:0]   ins_pos;
  logic signed [DATA_W-1:0]  read_data;
  cell_ctl_t                 ctl;

  logic signed [DATA_W-1:0]  entries  [CAPACITY];
  cell_flag_t                flags    [CAPACITY];
  logic        [CAPACITY-1:0] left_gt;
  logic        [CAPACITY-1:0] at_point;
  logic        [CAPACITY-1:0] eq_vec;

  assign step      = busy && (!rsp.valid || rsp.ready);
  assign req.ready = !busy || step;

  assign full = (count == CNT_W'(CAPACITY));

  assign ctl.value = item_value;
  assign ctl.load  = ins_go;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign left_gt[g] = 1'b1;
        sdui_cell u_cell (
          .clk        (clk),
          .ctl        (ctl),
          .occupied   (CNT_W'(g) < count),
          .left_entry ('0),
          .left_gt    (left_gt[g]),
          .entry      (entries[g]),
          .flag       (flags[g])
        );
      end else begin : g_body
        assign left_gt[g] = flags[g-1].gt;
        sdui_cell u_cell (
          .clk        (clk),
          .ctl        (ctl),
          .occupied   (CNT_W'(g) < count),
          .left_entry (entries[g-1]),
          .left_gt    (left_gt[g]),
          .entry      (entries[g]),
          .flag       (flags[g])
        );
      end
      assign at_point[g] = left_gt[g] && !flags[g].gt;
      assign eq_vec[g]   = flags[g].eq;
    end
  endgenerate

  assign any_eq = |eq_vec;
  assign ins_go = step && (item_kind == KIND_INSERT) && !any_eq && !full;

  // Greater entries form a prefix, so at most one slot marks the insert point
  // (none when every slot holds a greater entry); an equal entry sits at that same slot.
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      ins_pos = ins_pos | (at_point[i] ? IDX_W'(i) : '0);
    end
  end

  always_comb begin
    read_data = '0;
    for (int i = 0; i < READ_N; i++) begin
      if (item_index == INDEX_W'(i)) begin
        read_data = entries[i];
      end
    end
  end

  assign read_ok    = (CMP_W'(item_index) < CMP_W'(count));
  assign count_next = ins_go ? count + CNT_W'(1) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (req.valid && req.ready) begin
        busy <= 1'b1;
      end else if (step) begin
        busy <= 1'b0;
      end
      if (step) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item_kind  <= req.kind;
      item_value <= req.new_value;
      item_index <= req.read_index;
    end
    if (step) begin
      rsp.entry_count <= COUNT_W'(count_next);
      if (item_kind == KIND_READ) begin
        rsp.position <= item_index;
        if (read_ok) begin
          rsp.status     <= ST_READ_OK;
          rsp.entry_data <= read_data;
        end else begin
          rsp.status     <= ST_BEYOND;
          rsp.entry_data <= '0;
        end
      end else begin
        rsp.entry_data <= item_value;
        if (any_eq) begin
          rsp.status   <= ST_DUPLICATE;
          rsp.position <= INDEX_W'(ins_pos);
        end else if (full) begin
          rsp.status   <= ST_FULL;
          rsp.position <= '0;
        end else begin
          rsp.status   <= ST_INSERTED;
          rsp.position <= INDEX_W'(ins_pos);
        end
      end
    end
  end

endmodule

>>> sv/sdui_checker.sv
// ---------------------------------------------------------------------------
// sdui_checker
// Port-level checks on the sorted insert core, bound to the top level.
// ---------------------------------------------------------------------------
`include "sorted_descending_unique_insert_core_defines.svh"

module sdui_checker import sdui_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic        [STATUS_W-1:0] rsp_status,
  input logic        [INDEX_W-1:0]  rsp_position,
  input logic signed [DATA_W-1:0]   rsp_entry_data,
  input logic        [COUNT_W-1:0]  rsp_entry_count
);

  // Hold a stalled beat.
  `SDUI_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_position) && $stable(rsp_entry_data) && $stable(rsp_entry_count), "stalled response changed")

  `SDUI_ASSERT_IMPL(a_count_cap, clk, rst, rsp_valid, (CAPACITY > 31) || (32'(rsp_entry_count) <= 32'(CAPACITY)), "entry count above capacity")

  `SDUI_ASSERT_IMPL(a_beyond_zero, clk, rst, rsp_valid && (rsp_status == ST_BEYOND), rsp_entry_data == '0, "read beyond count returned data")

  `SDUI_ASSERT_IMPL(a_full_pos, clk, rst, rsp_valid && (rsp_status == ST_FULL), (rsp_position == '0) && ((CAPACITY > 31) || (32'(rsp_entry_count) == 32'(CAPACITY))), "full reject with bad position or count")

endmodule

bind sorted_descending_unique_insert_core sdui_checker #(.CAPACITY(CAPACITY)) u_sdui_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_position    (rsp.position),
  .rsp_entry_data  (rsp.entry_data),
  .rsp_entry_count (rsp.entry_count)
);

>>> verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives insert and read beats into the sorted insert core and checks every
// response against an in-bench copy of the descending table. Covers the empty
// table, extreme values, duplicates, appends, a full table, and random
// traffic under input and output stalls.
// ---------------------------------------------------------------------------
module testbench;
  import sdui_pkg::*;

  localparam int TABLE_DEPTH = CAPACITY_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    status_t                   status;
    logic        [INDEX_W-1:0] position;
    logic signed [DATA_W-1:0]  data;
    logic        [COUNT_W-1:0] count;
  } outcome_t;

  logic clk;
  logic rst;

  sdui_req_if req_ch ();
  sdui_rsp_if rsp_ch ();

  sorted_descending_unique_insert_core #(
    .CAPACITY(TABLE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Bench copy of the table state.
  logic signed [DATA_W-1:0]  table_vals [TABLE_DEPTH];
  logic        [COUNT_W-1:0] table_count = '0;

  outcome_t pending_outcomes [$];
  int error_count = 0;
  int stall_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int entry_index(logic signed [DATA_W-1:0] value);
    for (int i = 0; i < table_count; i++) begin
      if (table_vals[i] == value) return i;
    end
    return -1;
  endfunction

  // Apply one accepted beat to the bench table and return its response.
  function automatic outcome_t table_outcome(logic kind, logic signed [DATA_W-1:0] value,
                                             logic [INDEX_W-1:0] idx);
    int hit;
    int p;
    if (kind == KIND_READ) begin
      if (idx < table_count) return '{ST_READ_OK, idx, table_vals[idx], table_count};
      return '{ST_BEYOND, idx, '0, table_count};
    end
    hit = entry_index(value);
    if (hit >= 0) return '{ST_DUPLICATE, hit[INDEX_W-1:0], value, table_count};
    if (table_count >= TABLE_DEPTH) return '{ST_FULL, '0, value, table_count};
    p = 0;
    while (p < table_count && table_vals[p] > value) p++;
    for (int i = table_count; i > p; i--) table_vals[i] = table_vals[i-1];
    table_vals[p] = value;
    table_count = table_count + 1'b1;
    return '{ST_INSERTED, p[INDEX_W-1:0], value, table_count};
  endfunction

  task automatic report_mismatch(string what);
    if (error_count < MAX_PRINTED) $display("mismatch: %s", what);
    error_count++;
  endtask

  task automatic send_item(logic kind, logic signed [DATA_W-1:0] value,
                           logic [INDEX_W-1:0] idx);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.kind       <= kind;
    req_ch.new_value  <= value;
    req_ch.read_index <= idx;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (req_ch.ready === 1'b1);
      @(posedge clk);
    end
    pending_outcomes.push_back(table_outcome(kind, value, idx));
  endtask

  task automatic stop_sending();
    req_ch.valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(64)) - 32;
      2: return 32'sh7fffffff - $signed($urandom_range(3));
      default: return 32'sh80000000 + $signed($urandom_range(3));
    endcase
  endfunction

  task automatic random_item();
    int sel;
    sel = $urandom_range(99);
    if (sel < 35)
      send_item(KIND_READ, $urandom, INDEX_W'($urandom_range(15)));
    else if (sel < 75 && table_count != 0)
      send_item(KIND_INSERT, table_vals[$urandom_range(table_count - 1)],
                INDEX_W'($urandom_range(15)));
    else
      send_item(KIND_INSERT, random_value(), INDEX_W'($urandom_range(15)));
  endtask

  task automatic test_directed_edges();
    send_item(KIND_READ, 32'sd0, 4'd0);
    send_item(KIND_READ, -32'sd1, 4'd15);
    send_item(KIND_INSERT, 32'sd0, 4'd0);
    send_item(KIND_INSERT, 32'sd0, 4'd15);
    send_item(KIND_INSERT, 32'sh7fffffff, 4'd0);
    // smaller than every entry: append at the tail
    send_item(KIND_INSERT, 32'sh80000000, 4'd0);
    send_item(KIND_INSERT, -32'sd1, 4'd0);
    send_item(KIND_INSERT, 32'sd1, 4'd0);
    send_item(KIND_READ, 32'sd0, 4'd0);
    send_item(KIND_READ, 32'sd0, 4'd4);
    send_item(KIND_READ, 32'sd0, 4'd5);
    send_item(KIND_INSERT, 32'sh80000000, 4'd0);
    send_item(KIND_INSERT, 32'sh7fffffff, 4'd0);
  endtask

  task automatic test_fill_and_full();
    logic signed [DATA_W-1:0] fresh;
    while (table_count < TABLE_DEPTH)
      send_item(KIND_INSERT, random_value(), INDEX_W'($urandom_range(15)));
    fresh = $urandom;
    while (entry_index(fresh) >= 0) fresh = $urandom;
    send_item(KIND_INSERT, fresh, 4'd0);
    // duplicate still wins over full
    send_item(KIND_INSERT, table_vals[TABLE_DEPTH-1], 4'd0);
    send_item(KIND_READ, 32'sd0, 4'd15);
    send_item(KIND_READ, 32'sd0, 4'd0);
  endtask

  task automatic test_random_mix(int n);
    repeat (n) random_item();
  endtask

  task automatic test_output_backpressure();
    hold_request = HOLD_OFF_CYCLES;
    repeat (24) random_item();
  endtask

  task automatic test_drain_pause();
    stop_sending();
    wait_for_drain();
    repeat (30) random_item();
  endtask

  // Response side: random stalls plus an occasional long hold-off.
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(negedge clk) begin
    outcome_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("response with nothing pending, status %0d",
                                  rsp_ch.status));
      end else begin
        want = pending_outcomes.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch($sformatf("status got %0d expected %0d",
                                    rsp_ch.status, want.status));
        if (rsp_ch.position !== want.position)
          report_mismatch($sformatf("position got %0d expected %0d",
                                    rsp_ch.position, want.position));
        if (rsp_ch.entry_data !== want.data)
          report_mismatch($sformatf("entry_data got %0d expected %0d",
                                    rsp_ch.entry_data, want.data));
        if (rsp_ch.entry_count !== want.count)
          report_mismatch($sformatf("entry_count got %0d expected %0d",
                                    rsp_ch.entry_count, want.count));
      end
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  always @(negedge clk) begin
    if (!rst) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.kind       <= KIND_INSERT;
    req_ch.new_value  <= '0;
    req_ch.read_index <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 14;
    recv_idle_pct = 56;
    test_directed_edges();
    test_fill_and_full();
    test_random_mix(500);
    test_output_backpressure();

    send_idle_pct = 56;
    recv_idle_pct = 14;
    test_random_mix(550);
    test_drain_pause();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(550);

    stop_sending();
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
